FILE: design/sss_pkg.sv
// Shared types and constants for the scatter step scheduler.
// Used by the front classifier, the command queue, the back sequencer and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

  // Largest rank count the schedule supports, whatever the register holds.
  localparam int RANK_LIMIT = 64;

  // Most slices that one step can move.
  localparam logic [5:0] SLICE_MAX = 6'd32;

  // Configuration register indexes.
  localparam logic [1:0] REG_RANK_COUNT = 2'd0;
  localparam logic [1:0] REG_MY_RANK    = 2'd1;
  localparam logic [1:0] REG_ROOT_RANK  = 2'd2;

  // Action codes of a result.
  typedef enum logic [1:0] {
    ACT_IDLE = 2'd0,
    ACT_SEND = 2'd1,
    ACT_RECV = 2'd2
  } action_t;

  // One classified step, handed from the front to the back.
  typedef struct packed {
    action_t    action;
    logic [5:0] peer;
    logic [5:0] first_idx;
    logic [5:0] count;
    logic [5:0] stride;
    logic [6:0] ranks;
  } step_cmd_t;

endpackage

`default_nettype wire

FILE: design/sss_front.sv
// Front end: classifies one requested step into a step command.
// Depends on sss_pkg for the command struct and action codes.
`timescale 1ns / 1ps
`default_nettype none

module sss_front #(
  parameter int MAX_RANKS = 64
) (
  input  wire logic [6:0]        rank_count,
  input  wire logic [5:0]        my_rank,
  input  wire logic [5:0]        root_rank,
  input  wire logic [2:0]        step_index,
  output sss_pkg::step_cmd_t     cmd
);

  localparam int         CAP   = (MAX_RANKS < sss_pkg::RANK_LIMIT) ? MAX_RANKS
                                                                     : sss_pkg::RANK_LIMIT;
  localparam logic [6:0] CAP_N = 7'(CAP);

  logic [6:0] n;
  logic [2:0] total;
  logic       ok;
  logic [6:0] v;
  logic [6:0] r;
  logic [6:0] p;
  logic [7:0] two_p;
  logic [6:0] d;
  logic [6:0] k_sum;
  logic [6:0] k_raw;
  logic [5:0] k;
  logic [7:0] stride_w;
  logic       pow2;
  logic [6:0] g;
  logic [7:0] g_plus_p;
  logic       send;
  logic       recv;
  logic [6:0] peer_dn;
  logic [7:0] peer_up;

  // Effective rank count: zero reads as one, large values saturate.
  always_comb begin
    priority if (rank_count == 7'd0) begin
      n = 7'd1;
    end else if (rank_count > CAP_N) begin
      n = CAP_N;
    end else begin
      n = rank_count;
    end
  end

  // Number of steps is ceil(log2 n).
  always_comb begin
    priority if (n > 7'd32) begin
      total = 3'd6;
    end else if (n > 7'd16) begin
      total = 3'd5;
    end else if (n > 7'd8) begin
      total = 3'd4;
    end else if (n > 7'd4) begin
      total = 3'd3;
    end else if (n > 7'd2) begin
      total = 3'd2;
    end else if (n > 7'd1) begin
      total = 3'd1;
    end else begin
      total = 3'd0;
    end
  end

  assign v  = {1'b0, my_rank};
  assign r  = {1'b0, root_rank};
  assign ok = (step_index < total) && (v < n) && (r < n);

  // Step distance and the distance of this rank from the root.
  assign p     = 7'd1 << step_index;
  assign two_p = {1'b0, p} << 1;
  assign d     = (r >= v) ? (r - v) : (r + n - v);

  // Slice count, capped at SLICE_MAX, and the stride between slices modulo n.
  assign k_sum    = n - 7'd1 + p;
  assign k_raw    = k_sum >> ({1'b0, step_index} + 4'd1);
  assign k        = (k_raw > {1'b0, sss_pkg::SLICE_MAX}) ? sss_pkg::SLICE_MAX : k_raw[5:0];
  assign stride_w = (two_p >= {1'b0, n}) ? (two_p - {1'b0, n}) : two_p;

  // The last step of a non-power-of-two count works on a smaller group.
  assign pow2     = (n & (n - 7'd1)) == 7'd0;
  assign g        = (!pow2 && (step_index == total - 3'd1)) ? (n - p) : p;
  assign g_plus_p = {1'b0, g} + {1'b0, p};

  assign send = ok && (d < g);
  assign recv = ok && !send && (d >= p) && ({1'b0, d} < g_plus_p);

  // Peers one step distance below and above this rank.
  assign peer_dn = (v >= p) ? (v - p) : (v + n - p);
  assign peer_up = ({1'b0, v} + {1'b0, p} >= {1'b0, n}) ? ({1'b0, v} + {1'b0, p} - {1'b0, n})
                                                         : ({1'b0, v} + {1'b0, p});

  // Build the command; anything that is neither send nor receive, or has no slices, is idle.
  always_comb begin
    cmd        = '0;
    cmd.action = sss_pkg::ACT_IDLE;
    cmd.ranks  = n;
    if ((send || recv) && (k != 6'd0)) begin
      cmd.action    = send ? sss_pkg::ACT_SEND : sss_pkg::ACT_RECV;
      cmd.peer      = send ? peer_dn[5:0] : peer_up[5:0];
      cmd.first_idx = send ? peer_dn[5:0] : my_rank;
      cmd.count     = k;
      cmd.stride    = stride_w[5:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/sss_queue.sv
// Two-entry command queue between the front classifier and the back sequencer.
// Depends on sss_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module sss_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sss_pkg::step_cmd_t push_cmd,
  output logic                    full,
  input  wire logic               pop,
  output logic                    not_empty,
  output sss_pkg::step_cmd_t      head
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  sss_pkg::step_cmd_t entries [DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [PW:0]        fill;

  assign full      = fill == (PW+1)'(DEPTH);
  assign not_empty = fill != '0;
  assign head      = entries[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/sss_back.sv
// Back end: expands one step command into per-slice results, one per cycle while the output is not stalled.
// Depends on sss_pkg for the command struct and action codes.
`timescale 1ns / 1ps
`default_nettype none

module sss_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_avail,
  input  wire sss_pkg::step_cmd_t cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sss_pkg::action_t        out_action,
  output logic [5:0]              out_peer,
  output logic [5:0]              out_idx,
  output logic [5:0]              out_count,
  output logic                    out_last
);

  logic               busy;
  sss_pkg::step_cmd_t cur;
  logic [5:0]         remain;
  logic [5:0]         idx;
  logic               emit;
  logic [6:0]         idx_next;

  // A result moves into the output register whenever that register is free.
  assign emit    = busy && (!out_valid || !out_stall);
  assign cmd_pop = !busy && cmd_avail;

  // Next slice index steps down by the stride, modulo the rank count.
  assign idx_next = ({1'b0, idx} >= {1'b0, cur.stride})
                    ? ({1'b0, idx} - {1'b0, cur.stride})
                    : ({1'b0, idx} + cur.ranks - {1'b0, cur.stride});

  // Control: busy flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        if (remain == 6'd1) begin
          busy <= 1'b0;
        end
      end
      if (cmd_pop) begin
        busy <= 1'b1;
      end
    end
  end

  // Working command, slice counter and output payload.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur    <= cmd;
      idx    <= cmd.first_idx;
      remain <= (cmd.count == 6'd0) ? 6'd1 : cmd.count;
    end else if (emit) begin
      idx    <= idx_next[5:0];
      remain <= remain - 6'd1;
    end
    if (emit) begin
      out_action <= cur.action;
      out_peer   <= cur.peer;
      out_idx    <= idx;
      out_count  <= cur.count;
      out_last   <= remain == 6'd1;
    end
  end

endmodule

`default_nettype wire

FILE: design/scatter_step_schedule.sv
// Top level of the scatter step scheduler: configuration registers, front,
// queue and back. Depends on sss_pkg, sss_front, sss_queue and sss_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall    | step_index
//   out     | out       | out_valid/out_stall  | action, peer_rank, slice_index,
//           |           |                      | slice_count, last
//
// A request is classified in the cycle it is taken and queued (two entries).
// The back sequencer loads a queued step once it is idle, then emits one result per
// cycle while out_stall is low: slice_count results for a send or receive step, one
// for an idle step. Reset (rst, synchronous) empties the queue and sets rank_count
// to 2 and both ranks to 0. in_stall rises only while the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module scatter_step_schedule #(
  parameter int MAX_RANKS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] step_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      action,
  output logic [5:0]      peer_rank,
  output logic [5:0]      slice_index,
  output logic [5:0]      slice_count,
  output logic            last
);

  logic [6:0]         rank_count;
  logic [5:0]         my_rank;
  logic [5:0]         root_rank;
  sss_pkg::step_cmd_t front_cmd;
  sss_pkg::step_cmd_t head_cmd;
  logic               q_full;
  logic               q_avail;
  logic               q_pop;
  logic               push;
  sss_pkg::action_t   out_action;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count <= 7'd2;
      my_rank    <= 6'd0;
      root_rank  <= 6'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sss_pkg::REG_RANK_COUNT: rank_count <= cfg_data;
        sss_pkg::REG_MY_RANK:    my_rank    <= cfg_data[5:0];
        sss_pkg::REG_ROOT_RANK:  root_rank  <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Front classifier.
  sss_front #(
    .MAX_RANKS(MAX_RANKS)
  ) u_front (
    .rank_count(rank_count),
    .my_rank   (my_rank),
    .root_rank (root_rank),
    .step_index(step_index),
    .cmd       (front_cmd)
  );

  // Input handshake: take a request whenever the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  sss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_avail),
    .head     (head_cmd)
  );

  // Back sequencer.
  sss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (q_avail),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_action(out_action),
    .out_peer  (peer_rank),
    .out_idx   (slice_index),
    .out_count (slice_count),
    .out_last  (last)
  );

  assign action = out_action;

  // An idle result is always a single, final result with empty fields.
  a_idle_single : assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_action == sss_pkg::ACT_IDLE)
      |-> last && (slice_count == 6'd0) && (peer_rank == 6'd0))
    else $error("idle result is not a single empty result");

  // A send or receive result carries a slice count between one and the maximum.
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_action != sss_pkg::ACT_IDLE)
      |-> (slice_count != 6'd0) && (slice_count <= sss_pkg::SLICE_MAX))
    else $error("slice count out of range");

  // Once a non-final result is taken, the next slice of the same step follows at once.
  a_burst_unbroken : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last
      |=> out_valid && (action == $past(action)) && (slice_count == $past(slice_count)))
    else $error("step results interrupted");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for scatter_step_schedule: a directed pass over edge
// cases, then random configurations and steps, checked against a local predictor.
// Depends on sss_pkg and the scatter_step_schedule RTL.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_RANKS = 64;
  localparam int RANDOM_STEPS = 300;

  // The index past the register list; writes to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One expected result of a scheduled step.
  typedef struct packed {
    sss_pkg::action_t act;
    logic [5:0]       peer;
    logic [5:0]       slice;
    logic [5:0]       count;
    logic             last;
  } slice_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = sss_pkg::REG_RANK_COUNT;
  logic [6:0] cfg_data = 7'd0;
  logic       in_valid = 1'b0;
  logic [2:0] step_index = 3'd0;
  logic       out_stall = 1'b0;
  logic       cfg_ready;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] action;
  logic [5:0] peer_rank;
  logic [5:0] slice_index;
  logic [5:0] slice_count;
  logic       last;

  // Shadow copy of the configuration registers.
  logic [6:0] cfg_ranks = 7'd2;
  logic [5:0] cfg_my = 6'd0;
  logic [5:0] cfg_root = 6'd0;

  logic [2:0]    pending_steps[$];
  slice_result_t expected_slices[$];
  int            mismatch_count = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  bit            quiet = 1'b0;

  scatter_step_schedule #(.MAX_RANKS(MAX_RANKS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .step_index(step_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .action(action),
    .peer_rank(peer_rank),
    .slice_index(slice_index),
    .slice_count(slice_count),
    .last(last)
  );

  always #10 clk = ~clk;

  // Idle span for either side: mostly none or short, now and then long.
  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Works out the slice results of one step under the shadow configuration.
  function automatic void schedule_step(input logic [2:0] step);
    int unsigned      n, s, total, v, r, p, d, k, stride, g, idx, i;
    sss_pkg::action_t act;
    logic [5:0]       peer;
    n = cfg_ranks;
    if (n == 0) n = 1;
    if (n > sss_pkg::RANK_LIMIT) n = sss_pkg::RANK_LIMIT;
    if (n > MAX_RANKS) n = MAX_RANKS;
    s = step;
    v = cfg_my;
    r = cfg_root;
    k = 0;
    idx = 0;
    peer = 6'd0;
    act = sss_pkg::ACT_IDLE;
    total = 0;
    while (total < 31 && (1 << total) < n) total++;
    if (s < total && v < n && r < n) begin
      p = 1 << s;
      d = (r + n - v) % n;
      k = (n - 1 + p) / (2 * p);
      stride = (2 * p) % n;
      // The last step of a non-power-of-two count serves a smaller group.
      g = ((n & (n - 1)) != 0 && s == total - 1) ? n - p : p;
      if (d < g) begin
        act = sss_pkg::ACT_SEND;
        peer = 6'((v + n - p) % n);
        idx = peer;
      end else if (d >= p && d < g + p) begin
        act = sss_pkg::ACT_RECV;
        peer = 6'((v + p) % n);
        idx = v;
      end
      if (k > 32) k = 32;
    end
    if (act == sss_pkg::ACT_IDLE || k == 0) begin
      expected_slices.insert(expected_slices.size(),
                             '{sss_pkg::ACT_IDLE, 6'd0, 6'd0, 6'd0, 1'b1});
    end else begin
      for (i = 0; i < k; i++) begin
        expected_slices.insert(expected_slices.size(),
                               '{act, peer, 6'(idx), 6'(k), (i + 1 == k)});
        idx = (idx + n - stride) % n;
      end
    end
  endfunction

  // Request driver: presents queued steps with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_steps.size() != 0) begin
        step_index <= pending_steps.pop_front();
        in_valid <= 1'b1;
        send_gap = quiet ? 0 : idle_span();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: tracks register writes, predicts accepted requests, checks results
  // and stalls the output at random.
  always @(posedge clk) begin
    slice_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sss_pkg::REG_RANK_COUNT: cfg_ranks = cfg_data;
          sss_pkg::REG_MY_RANK:    cfg_my = cfg_data[5:0];
          sss_pkg::REG_ROOT_RANK:  cfg_root = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) schedule_step(step_index);
      if (out_valid && !out_stall) begin
        if (expected_slices.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: result with none expected: ",
                      "act %0d peer %0d slice %0d count %0d last %0d"},
                     $realtime, action, peer_rank, slice_index, slice_count, last);
        end else begin
          want = expected_slices.pop_front();
          if (action !== want.act || peer_rank !== want.peer || slice_index !== want.slice ||
              slice_count !== want.count || last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: expected act %0d peer %0d slice %0d count %0d last %0d, ",
                        "got %0d %0d %0d %0d %0d"},
                       $realtime, want.act, want.peer, want.slice, want.count, want.last,
                       action, peer_rank, slice_index, slice_count, last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_span();
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // Waits until every request has been taken and every result has arrived.
  // The check runs just after each edge, once the driver and monitor have
  // settled, and the task returns on a rising edge.
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_steps.size() != 0 || in_valid || expected_slices.size() != 0);
    @(posedge clk);
  endtask

  // Holds one register write until the block takes it; the caller lowers valid.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  task automatic set_config(input logic [6:0] ranks, input logic [5:0] me,
                            input logic [5:0] root, input bit poke_unused);
    drain();
    if (poke_unused) write_reg(REG_UNUSED, 7'($urandom_range(0, 127)));
    write_reg(sss_pkg::REG_RANK_COUNT, ranks);
    write_reg(sss_pkg::REG_MY_RANK, {1'b0, me});
    write_reg(sss_pkg::REG_ROOT_RANK, {1'b0, root});
    cfg_valid <= 1'b0;
  endtask

  // Directed phase: one configuration, then the steps whose mask bits are set.
  task automatic directed_phase(input logic [6:0] ranks, input logic [5:0] me,
                                input logic [5:0] root, input logic [7:0] step_mask);
    int s;
    set_config(ranks, me, root, 1'b1);
    for (s = 0; s < 8; s++)
      if (step_mask[s]) pending_steps.insert(pending_steps.size(), 3'(s));
  endtask

  initial begin : stimulus
    int issued, burst, roll, ranks, eff, total, me, root, j;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration, including a step past the end.
    directed_phase(7'd2, 6'd0, 6'd0, 8'b1000_0011);
    // Root of 64 ranks: 32-slice send first, then every step code.
    directed_phase(7'd64, 6'd0, 6'd0, 8'hFF);
    directed_phase(7'd64, 6'd32, 6'd0, 8'b0011_0000);
    // Non-power-of-two count shrinks the last group.
    directed_phase(7'd5, 6'd4, 6'd0, 8'b0000_0111);
    // Rank count zero and one leave nothing to do.
    directed_phase(7'd0, 6'd0, 6'd0, 8'h01);
    directed_phase(7'd1, 6'd0, 6'd0, 8'h01);
    // Oversized rank count saturates to 64; receive of 32 slices.
    directed_phase(7'd127, 6'd63, 6'd0, 8'b0010_0001);
    // Own rank or root rank outside the group.
    directed_phase(7'd6, 6'd6, 6'd0, 8'h01);
    directed_phase(7'd6, 6'd0, 6'd63, 8'h02);

    // Random phases: a fresh configuration, then a burst of steps. Each new
    // configuration waits for the previous burst to drain completely.
    issued = 0;
    while (issued < RANDOM_STEPS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) ranks = $urandom_range(0, 1);
      else if (roll < 16) ranks = $urandom_range(64, 127);
      else if (roll < 36) ranks = 1 << $urandom_range(1, 6);
      else ranks = $urandom_range(2, 64);
      eff = (ranks == 0) ? 1 : ((ranks > 64) ? 64 : ranks);
      total = 0;
      while ((1 << total) < eff) total++;
      if ($urandom_range(0, 99) < 85) begin
        me = $urandom_range(0, eff - 1);
        root = ($urandom_range(0, 3) == 0) ? me : $urandom_range(0, eff - 1);
      end else begin
        me = $urandom_range(0, 63);
        root = $urandom_range(0, 63);
      end
      set_config(7'(ranks), 6'(me), 6'(root), $urandom_range(0, 3) == 0);
      quiet = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(5, 30);
      for (j = 0; j < burst; j++) begin
        if (total > 0 && $urandom_range(0, 99) < 85)
          pending_steps.insert(pending_steps.size(), 3'($urandom_range(0, total - 1)));
        else
          pending_steps.insert(pending_steps.size(), 3'($urandom_range(0, 7)));
      end
      issued += burst;
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_slices.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(50_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
design/sss_pkg.sv
design/sss_front.sv
design/sss_queue.sv
design/sss_back.sv
design/scatter_step_schedule.sv
tb/sv/tb.sv
